FILE: rtl/core/prq_pkg.sv
// shared types, codes and defaults of the priority run queue
`default_nettype none
package prq_pkg;

    localparam int TASK_ID_W = 6;
    localparam int SLICE_W   = 16;
    localparam int PRIO_IN_W = 8;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;

    localparam int MAX_TASKS_DEF     = 64;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int STAMP_BITS_DEF    = 32;

    localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 16'd5;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_PICK = 2'd2;
    localparam logic [1:0] ACT_TICK = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTQ = 2'd2;

    typedef struct packed {
        logic                 enq;
        logic                 deq;
        logic                 tick;
        logic [TASK_ID_W-1:0] task_id;
        logic [SLICE_W-1:0]   slice;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/prq_cell.sv
// one task slot of the run queue and its stage of the pick scan
`default_nettype none
module prq_cell #(
    parameter int IDX           = 0,
    parameter int ID_BITS       = 6,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF,
    parameter int STAMP_BITS    = prq_pkg::STAMP_BITS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  prq_pkg::cmd_t           cmd,
    input  wire [PRIORITY_BITS-1:0] prio_new,
    input  wire [STAMP_BITS-1:0]    stamp_new,
    input  wire                     tok_in_valid,
    input  wire                     tok_in_found,
    input  wire [PRIORITY_BITS-1:0] tok_in_prio,
    input  wire [STAMP_BITS-1:0]    tok_in_stamp,
    input  wire [ID_BITS-1:0]       tok_in_id,
    output logic                    tok_out_valid,
    output logic                    tok_out_found,
    output logic [PRIORITY_BITS-1:0] tok_out_prio,
    output logic [STAMP_BITS-1:0]   tok_out_stamp,
    output logic [ID_BITS-1:0]      tok_out_id,
    output logic                    hit_queued,
    output logic                    tick_zero
);

    logic                          queued_reg;
    logic [prq_pkg::SLICE_W-1:0]   slice_reg;
    logic [prq_pkg::SLICE_W-1:0]   slice_dec;
    logic [PRIORITY_BITS-1:0]      prio_reg;
    logic [STAMP_BITS-1:0]         stamp_reg;
    logic                          hit;
    logic                          take;
    logic                          tok_valid_reg;
    logic                          tok_found_reg;
    logic [PRIORITY_BITS-1:0]      tok_prio_reg;
    logic [STAMP_BITS-1:0]         tok_stamp_reg;
    logic [ID_BITS-1:0]            tok_id_reg;

    assign hit       = (int'(cmd.task_id) == IDX);
    assign slice_dec = slice_reg - ((slice_reg != '0) ? 16'd1 : 16'd0);
    assign hit_queued = hit && queued_reg;
    assign tick_zero  = hit && (slice_dec == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= 1'b0;
            slice_reg  <= '0;
        end
        else if (hit)
        begin
            if (cmd.enq && !queued_reg)
            begin
                queued_reg <= 1'b1;
                slice_reg  <= cmd.slice;
            end
            else if (cmd.deq && queued_reg)
            begin
                queued_reg <= 1'b0;
            end
            else if (cmd.tick)
            begin
                slice_reg <= slice_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.enq && !queued_reg)
        begin
            prio_reg  <= prio_new;
            stamp_reg <= stamp_new;
        end
    end

    // better priority, or same priority and older stamp
    assign take = queued_reg && (!tok_in_found || (prio_reg > tok_in_prio) ||
                  ((prio_reg == tok_in_prio) && (stamp_reg < tok_in_stamp)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_found_reg <= 1'b1;
            tok_prio_reg  <= prio_reg;
            tok_stamp_reg <= stamp_reg;
            tok_id_reg    <= ID_BITS'(IDX);
        end
        else
        begin
            tok_found_reg <= tok_in_found;
            tok_prio_reg  <= tok_in_prio;
            tok_stamp_reg <= tok_in_stamp;
            tok_id_reg    <= tok_in_id;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_found = tok_found_reg;
    assign tok_out_prio  = tok_prio_reg;
    assign tok_out_stamp = tok_stamp_reg;
    assign tok_out_id    = tok_id_reg;

endmodule
`default_nettype wire

FILE: rtl/core/priority_run_queue.sv
// top level of the priority run queue: a row of task slot cells
// enqueue, dequeue and tick: result registered in the cycle after the input beat
// pick: a best-so-far token walks the cell row one slot per cycle, result
//   registered once the token leaves the last cell, one item at a time
// reset clears queued marks, slices, stamp counter, task count; max_slice = 5
`default_nettype none
module priority_run_queue #(
    parameter int MAX_TASKS     = prq_pkg::MAX_TASKS_DEF,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF,
    parameter int STAMP_BITS    = prq_pkg::STAMP_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [prq_pkg::SLICE_W-1:0]      max_slice,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire [1:0]                       action,
    input  wire [prq_pkg::TASK_ID_W-1:0]    task_id,
    input  wire [prq_pkg::PRIO_IN_W-1:0]    priority_req,
    input  wire [prq_pkg::SLICE_W-1:0]      slice_in,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [prq_pkg::TASK_ID_W-1:0]   next_task,
    output logic                            next_valid,
    output logic                            resched_flag,
    output logic [prq_pkg::COUNT_W-1:0]     queue_count,
    output logic [prq_pkg::STATUS_W-1:0]    status
);

    localparam int ID_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);

    logic [prq_pkg::SLICE_W-1:0] max_slice_reg;
    logic [STAMP_BITS-1:0]       stamp_reg;
    logic [STAMP_BITS-1:0]       stamp_inc;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        busy_reg;
    logic                        out_valid_reg;
    logic [prq_pkg::TASK_ID_W-1:0] next_task_reg;
    logic                        next_valid_reg;
    logic                        resched_reg;
    logic [prq_pkg::COUNT_W-1:0] count_out_reg;
    logic [prq_pkg::STATUS_W-1:0] status_reg;

    logic                        accept;
    logic                        do_enq;
    logic                        do_deq;
    logic                        do_pick;
    logic                        do_tick;
    logic                        in_range;
    logic                        any_queued;
    logic                        any_zero;
    logic                        enq_ok;
    logic                        deq_ok;
    logic [prq_pkg::SLICE_W-1:0] slice_clamped;
    logic [prq_pkg::STATUS_W-1:0] status_next;
    prq_pkg::cmd_t               cmd;

    logic [MAX_TASKS:0]          tok_valid;
    logic [MAX_TASKS:0]          tok_found;
    logic [PRIORITY_BITS-1:0]    tok_prio  [MAX_TASKS+1];
    logic [STAMP_BITS-1:0]       tok_stamp [MAX_TASKS+1];
    logic [ID_BITS-1:0]          tok_id    [MAX_TASKS+1];
    logic [MAX_TASKS-1:0]        hitq_vec;
    logic [MAX_TASKS-1:0]        zero_vec;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign in_range  = int'(task_id) < MAX_TASKS;

    always_comb
    begin
        do_enq  = 1'b0;
        do_deq  = 1'b0;
        do_pick = 1'b0;
        do_tick = 1'b0;
        unique case (action)
            prq_pkg::ACT_ENQ:  do_enq  = accept;
            prq_pkg::ACT_DEQ:  do_deq  = accept;
            prq_pkg::ACT_PICK: do_pick = accept;
            prq_pkg::ACT_TICK: do_tick = accept;
            default: ;
        endcase
    end

    assign slice_clamped = ((slice_in == '0) || (slice_in > max_slice_reg)) ?
                           max_slice_reg : slice_in;
    assign stamp_inc = stamp_reg + 1'b1;

    assign cmd.enq     = do_enq;
    assign cmd.deq     = do_deq;
    assign cmd.tick    = do_tick;
    assign cmd.task_id = task_id;
    assign cmd.slice   = slice_clamped;

    assign tok_valid[0] = do_pick;
    assign tok_found[0] = 1'b0;
    assign tok_prio[0]  = '0;
    assign tok_stamp[0] = '0;
    assign tok_id[0]    = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        prq_cell #(
            .IDX           (i),
            .ID_BITS       (ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS),
            .STAMP_BITS    (STAMP_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .prio_new      (PRIORITY_BITS'(priority_req)),
            .stamp_new     (stamp_inc),
            .tok_in_valid  (tok_valid[i]),
            .tok_in_found  (tok_found[i]),
            .tok_in_prio   (tok_prio[i]),
            .tok_in_stamp  (tok_stamp[i]),
            .tok_in_id     (tok_id[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out_found (tok_found[i+1]),
            .tok_out_prio  (tok_prio[i+1]),
            .tok_out_stamp (tok_stamp[i+1]),
            .tok_out_id    (tok_id[i+1]),
            .hit_queued    (hitq_vec[i]),
            .tick_zero     (zero_vec[i])
        );
    end

    assign any_queued = |hitq_vec;
    assign any_zero   = |zero_vec;
    assign enq_ok     = do_enq && in_range && !any_queued;
    assign deq_ok     = do_deq && in_range && any_queued;

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        status_next = prq_pkg::ST_OK;
        if (do_enq && in_range && any_queued)
        begin
            status_next = prq_pkg::ST_DUP;
        end
        else if (do_deq && in_range && !any_queued)
        begin
            status_next = prq_pkg::ST_NOTQ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slice_reg <= prq_pkg::MAX_SLICE_RST;
            stamp_reg     <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_slice_reg <= max_slice;
            end
            if (enq_ok)
            begin
                stamp_reg <= stamp_inc;
            end
            count_reg <= count_next;
            if (do_pick)
            begin
                busy_reg <= 1'b1;
            end
            else if (tok_valid[MAX_TASKS])
            begin
                busy_reg <= 1'b0;
            end
            if ((accept && !do_pick) || tok_valid[MAX_TASKS])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload for both the direct actions and the end of a scan
    always_ff @(posedge clk)
    begin
        if (accept && !do_pick)
        begin
            next_task_reg  <= '0;
            next_valid_reg <= 1'b0;
            resched_reg    <= do_tick && in_range && any_zero;
            count_out_reg  <= prq_pkg::COUNT_W'(count_next);
            status_reg     <= status_next;
        end
        else if (tok_valid[MAX_TASKS])
        begin
            next_task_reg  <= tok_found[MAX_TASKS] ?
                              prq_pkg::TASK_ID_W'(tok_id[MAX_TASKS]) : '0;
            next_valid_reg <= tok_found[MAX_TASKS];
            resched_reg    <= 1'b0;
            count_out_reg  <= prq_pkg::COUNT_W'(count_reg);
            status_reg     <= prq_pkg::ST_OK;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_task    = next_task_reg;
    assign next_valid   = next_valid_reg;
    assign resched_flag = resched_reg;
    assign queue_count  = count_out_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

FILE: rtl/core/prq_checker.sv
// port-level checks of the priority run queue and their binding
`default_nettype none
module prq_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_stall,
    input wire [5:0] next_task,
    input wire       next_valid,
    input wire       resched_flag,
    input wire [1:0] status
);

    // a stalled result beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_task))
        else $error("stalled result beat dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // a valid pick result carries no error and no reschedule
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_valid |-> status == prq_pkg::ST_OK && !resched_flag)
        else $error("pick result mixed with other flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !next_valid |-> next_task == 6'd0)
        else $error("task id without a valid pick");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && resched_flag |-> status == prq_pkg::ST_OK)
        else $error("reschedule with error status");

endmodule

bind priority_run_queue prq_checker u_prq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_task    (next_task),
    .next_valid   (next_valid),
    .resched_flag (resched_flag),
    .status       (status)
);
`default_nettype wire

FILE: dv/tb.sv
// testbench of the priority run queue: random and directed actions checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;

    typedef struct packed {
        logic [prq_pkg::TASK_ID_W-1:0] next_task;
        logic                          next_valid;
        logic                          resched_flag;
        logic [prq_pkg::COUNT_W-1:0]   queue_count;
        logic [prq_pkg::STATUS_W-1:0]  status;
    } sched_result_t;

    class run_queue_scoreboard;
        bit             queued [64];
        bit [7:0]       prio [64];
        bit [31:0]      stamp [64];
        bit [15:0]      slice_left [64];
        bit [31:0]      stamp_ctr;
        int             task_total;
        bit [15:0]      slice_cap;
        sched_result_t  pending [$];
        int             mismatches;

        function new();
            stamp_ctr = 0;
            task_total = 0;
            slice_cap = prq_pkg::MAX_SLICE_RST;
            mismatches = 0;
            foreach (queued[i])
            begin
                queued[i] = 0;
                slice_left[i] = 0;
                prio[i] = 0;
                stamp[i] = 0;
            end
        endfunction

        function void note_action(bit [1:0] act, bit [5:0] id, bit [7:0] p, bit [15:0] sl);
            sched_result_t r;
            int best;
            r = '0;
            best = -1;
            case (act)
                prq_pkg::ACT_ENQ:
                begin
                    if (queued[id])
                        r.status = prq_pkg::ST_DUP;
                    else
                    begin
                        stamp_ctr = stamp_ctr + 32'd1;
                        stamp[id] = stamp_ctr;
                        prio[id] = p;
                        slice_left[id] = (sl == 0 || sl > slice_cap) ? slice_cap : sl;
                        queued[id] = 1;
                        task_total++;
                    end
                end
                prq_pkg::ACT_DEQ:
                begin
                    if (!queued[id])
                        r.status = prq_pkg::ST_NOTQ;
                    else
                    begin
                        queued[id] = 0;
                        task_total--;
                    end
                end
                prq_pkg::ACT_PICK:
                begin
                    for (int i = 0; i < 64; i++)
                        if (queued[i] && (best < 0 || prio[i] > prio[best] ||
                            (prio[i] == prio[best] && stamp[i] < stamp[best])))
                            best = i;
                    if (best >= 0)
                    begin
                        r.next_task = prq_pkg::TASK_ID_W'(best);
                        r.next_valid = 1;
                    end
                end
                default:
                begin
                    if (slice_left[id] > 0)
                        slice_left[id]--;
                    r.resched_flag = (slice_left[id] == 0);
                end
            endcase
            r.queue_count = prq_pkg::COUNT_W'(task_total);
            pending.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [prq_pkg::SLICE_W-1:0] max_slice;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] action;
    logic [prq_pkg::TASK_ID_W-1:0] task_id, next_task;
    logic [prq_pkg::PRIO_IN_W-1:0] priority_req;
    logic [prq_pkg::SLICE_W-1:0] slice_in;
    logic next_valid, resched_flag;
    logic [prq_pkg::COUNT_W-1:0] queue_count;
    logic [prq_pkg::STATUS_W-1:0] status;

    run_queue_scoreboard sb;
    bit idle_on;
    bit hold_long;

    priority_run_queue dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb: errors");
        $finish;
    end

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                out_stall <= 0;
                hold_long = 0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result({next_task, next_valid, resched_flag, queue_count, status});

    // valid stays high between back-to-back beats and drops only for a gap
    task automatic send_action(bit [1:0] act, bit [5:0] id, bit [7:0] p, bit [15:0] sl);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        task_id <= id;
        priority_req <= p;
        slice_in <= sl;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_action(act, id, p, sl);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cap(bit [15:0] v);
        drain();
        cfg_valid <= 1;
        max_slice <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        sb.slice_cap = v;
    endtask

    task automatic random_burst(int n, bit [5:0] id_span);
        bit [1:0] a;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 9);
            a = r < 4 ? prq_pkg::ACT_ENQ : r < 6 ? prq_pkg::ACT_DEQ :
                r < 8 ? prq_pkg::ACT_PICK : prq_pkg::ACT_TICK;
            send_action(a, 6'($urandom_range(0, id_span)),
                8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8) :
                    $urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        sb = new();
        idle_on = 0;
        hold_long = 0;
        rst_n = 0;
        cfg_valid = 0;
        max_slice = 0;
        in_valid = 0;
        action = prq_pkg::ACT_PICK;
        task_id = 0;
        priority_req = 0;
        slice_in = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_action(prq_pkg::ACT_PICK, 0, 0, 0);
        send_action(prq_pkg::ACT_DEQ, 63, 0, 0);
        send_action(prq_pkg::ACT_TICK, 7, 0, 0);
        send_action(prq_pkg::ACT_ENQ, 0, 8'h00, 16'h0000);
        send_action(prq_pkg::ACT_ENQ, 63, 8'hff, 16'hffff);
        send_action(prq_pkg::ACT_ENQ, 5, 8'hff, 16'h0003);
        send_action(prq_pkg::ACT_ENQ, 5, 8'h10, 16'h0001);
        send_action(prq_pkg::ACT_PICK, 0, 0, 0);
        send_action(prq_pkg::ACT_TICK, 5, 0, 0);
        send_action(prq_pkg::ACT_TICK, 5, 0, 0);
        send_action(prq_pkg::ACT_TICK, 5, 0, 0);
        send_action(prq_pkg::ACT_TICK, 5, 0, 0);
        send_action(prq_pkg::ACT_DEQ, 63, 0, 0);
        send_action(prq_pkg::ACT_PICK, 0, 0, 0);
        send_action(prq_pkg::ACT_DEQ, 63, 0, 0);
        send_action(prq_pkg::ACT_TICK, 0, 0, 0);
        send_action(prq_pkg::ACT_ENQ, 42, 8'haa, 16'h5555);
        send_action(prq_pkg::ACT_ENQ, 21, 8'h55, 16'haaaa);
        send_action(prq_pkg::ACT_PICK, 0, 0, 0);

        write_cap(16'd0);
        send_action(prq_pkg::ACT_ENQ, 9, 8'h01, 16'd7);
        send_action(prq_pkg::ACT_TICK, 9, 0, 0);
        write_cap(16'hffff);
        send_action(prq_pkg::ACT_ENQ, 10, 8'h01, 16'hffff);

        idle_on = 1;
        // fill all slots, then pick repeatedly
        for (int i = 0; i < 64; i++)
            send_action(prq_pkg::ACT_ENQ, 6'(i), 8'($urandom_range(0, 3)),
                16'($urandom_range(0, 65535)));
        repeat (10) send_action(prq_pkg::ACT_PICK, 0, 0, 0);
        write_cap(16'd1);
        random_burst(250, 15);
        hold_long = 1;
        random_burst(200, 63);
        drain();
        random_burst(30, 63);
        write_cap(16'($urandom_range(2, 100)));
        random_burst(300, 63);
        write_cap(16'd5);
        random_burst(150, 7);
        idle_on = 0;
        random_burst(120, 63);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
